@@ hdl/sequential_random_sampler_defines.svh @@
// Assertion macros used by the sampler RTL.
`ifndef SEQUENTIAL_RANDOM_SAMPLER_DEFINES_SVH
`define SEQUENTIAL_RANDOM_SAMPLER_DEFINES_SVH

// Same-cycle implication, checked on clk_i and disabled in reset.
`define SRS_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sampler check failed");

// Next-cycle implication, checked on clk_i and disabled in reset.
`define SRS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sampler check failed");

`endif

@@ hdl/srs_pkg.sv @@
// Types and constants of the sequential random sampler.
package srs_pkg;

  localparam int unsigned DataWidth       = 32;
  localparam int unsigned RandWidth       = 31;
  localparam int unsigned DefaultIndexBits = 32;
  localparam int unsigned DivCountWidth   = 6;

  typedef enum logic [1:0] {
    REG_POPULATION = 2'd0,
    REG_SAMPLE     = 2'd1,
    REG_BASE       = 2'd2
  } reg_idx_e;

  typedef enum logic {
    CMD_RESTART = 1'b0,
    CMD_DRAW    = 1'b1
  } cmd_e;

  typedef struct packed {
    logic                 command;
    logic [RandWidth-1:0] random_value;
  } in_beat_t;

  typedef struct packed {
    logic [DataWidth-1:0] sample_index;
    logic                 last_sample;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_MUL,
    ST_DIVSTART,
    ST_EMIT
  } state_e;

  // Request to the shared divider.
  typedef struct packed {
    logic                 start;
    logic [DataWidth-1:0] hi;
    logic [DataWidth-1:0] lo;
    logic [DataWidth-1:0] divisor;
  } div_req_t;

  // Result of the shared divider.
  typedef struct packed {
    logic                 done;
    logic [DataWidth-1:0] quotient;
    logic [DataWidth-1:0] remainder;
  } div_rsp_t;

endpackage

@@ hdl/sequential_random_sampler.sv @@
// Sequential random sampler (algorithm A): picks ordered distinct row indices.
//
// The block picks sample_size distinct row indices, in increasing order, out of
// population_size rows. A restart beat (command 0) loads the working state from
// the configuration registers and returns nothing. Each draw beat (command 1)
// carries one 31-bit random word and returns one output beat holding the next
// index plus base_offset, with last_sample set on the final index; a draw after
// the sample is exhausted returns nothing. When the sample covers the whole
// population the indices come out in order and the random word is ignored.
// A restart or an exhausted draw leaves the block idle at once, and a
// whole-population pick goes straight to the emit state. A normal pick starts
// the divider as its input beat is accepted, waits for the first quotient, runs
// the skip test and then loads the output register. Every row it skips adds one
// multiply and one 32-step division, since each skip runs through a single
// shared bit-serial divider. The last pick runs one division for its modulo.
// A full output register holds the emit state until the receiver takes the
// waiting beat. The block takes no new beat while a pick is in work,
// but it does accept one while a result still waits at the output register.
module sequential_random_sampler import srs_pkg::*; #(
  parameter int unsigned INDEX_BITS = DefaultIndexBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [DataWidth-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_beat_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_beat_t            out_data_o
);

`include "sequential_random_sampler_defines.svh"

  // The position is one bit wider than the index so that minus one is held.
  localparam int unsigned PosWidth = INDEX_BITS + 1;

  logic [DataWidth-1:0] pop_q, samp_q, base_q;

  state_e               state_q, state_d;
  logic [DataWidth-1:0] top_q, top_d;       // rows still to be skipped
  logic [DataWidth-1:0] cnt_q, cnt_d;       // rows not yet passed
  logic [PosWidth-1:0]  pos_q, pos_d;       // last emitted row
  logic [DataWidth-1:0] picks_q, picks_d;
  logic                 copy_q, copy_d;
  logic                 final_q, final_d;   // divider is computing the last skip
  logic                 last_q, last_d;
  logic [DataWidth-1:0] frac_q, frac_d;
  logic [DataWidth-1:0] quot_q, quot_d;
  logic [2*DataWidth-1:0] prod_q, prod_d;
  logic                 out_valid_q, out_valid_d;
  out_beat_t            out_q, out_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                 accept;
  logic [63:0]          idx_sum;

  srs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop_q  <= '0;
      samp_q <= '0;
      base_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_POPULATION: pop_q  <= cfg_data_i;
        REG_SAMPLE:     samp_q <= cfg_data_i;
        REG_BASE:       base_q <= cfg_data_i;
        default:        ;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign idx_sum    = 64'(pos_q) + 64'(base_q);

  always_comb begin
    state_d     = state_q;
    top_d       = top_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    picks_d     = picks_q;
    copy_d      = copy_q;
    final_d     = final_q;
    last_d      = last_q;
    frac_d      = frac_q;
    quot_d      = quot_q;
    prod_d      = prod_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    div_req     = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_data_i.command == CMD_RESTART) begin
            pos_d = '1;
            if (samp_q == '0) begin
              copy_d  = 1'b0;
              picks_d = '0;
              top_d   = '0;
              cnt_d   = '0;
            end else if (pop_q <= samp_q) begin
              copy_d  = 1'b1;
              picks_d = pop_q;
              top_d   = '0;
              cnt_d   = pop_q;
            end else begin
              copy_d  = 1'b0;
              picks_d = samp_q;
              top_d   = pop_q - samp_q;
              cnt_d   = pop_q;
            end
          end else if (picks_q == '0) begin
            // Sample exhausted or never loaded: nothing to return.
          end else if (copy_q) begin
            pos_d   = pos_q + 1'b1;
            picks_d = picks_q - 1'b1;
            last_d  = (picks_q == DataWidth'(1));
            state_d = ST_EMIT;
          end else if (picks_q != DataWidth'(1)) begin
            frac_d  = {in_data_i.random_value, 1'b0};
            final_d = 1'b0;
            if (cnt_q != '0) begin
              div_req.start   = 1'b1;
              div_req.hi      = top_q;
              div_req.lo      = '0;
              div_req.divisor = cnt_q;
              state_d         = ST_DIV;
            end else begin
              quot_d  = '0;
              state_d = ST_CHECK;
            end
          end else begin
            final_d = 1'b1;
            if (cnt_q != '0) begin
              div_req.start   = 1'b1;
              div_req.hi      = '0;
              div_req.lo      = {1'b0, in_data_i.random_value};
              div_req.divisor = cnt_q;
              state_d         = ST_DIV;
            end else begin
              pos_d   = pos_q + 1'b1;
              picks_d = '0;
              last_d  = 1'b1;
              state_d = ST_EMIT;
            end
          end
        end
      end

      ST_DIV: begin
        if (div_rsp.done) begin
          if (final_q) begin
            // The last pick skips random_value mod rows_remaining rows.
            pos_d   = pos_q + PosWidth'(div_rsp.remainder) + 1'b1;
            picks_d = '0;
            last_d  = 1'b1;
            state_d = ST_EMIT;
          end else begin
            quot_d  = div_rsp.quotient;
            state_d = ST_CHECK;
          end
        end
      end

      ST_CHECK: begin
        if ((quot_q > frac_q) && (top_q != '0) && (cnt_q != '0)) begin
          top_d = top_q - 1'b1;
          cnt_d = cnt_q - 1'b1;
          pos_d = pos_q + 1'b1;
          if (cnt_q != DataWidth'(1)) begin
            state_d = ST_MUL;
          end else begin
            quot_d = '0;
          end
        end else begin
          pos_d   = pos_q + 1'b1;
          if (cnt_q != '0) begin
            cnt_d = cnt_q - 1'b1;
          end
          picks_d = picks_q - 1'b1;
          last_d  = 1'b0;
          state_d = ST_EMIT;
        end
      end

      ST_MUL: begin
        prod_d  = quot_q * top_q;
        state_d = ST_DIVSTART;
      end

      ST_DIVSTART: begin
        div_req.start   = 1'b1;
        div_req.hi      = prod_q[2*DataWidth-1:DataWidth];
        div_req.lo      = prod_q[DataWidth-1:0];
        div_req.divisor = cnt_q;
        state_d         = ST_DIV;
      end

      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d            = 1'b1;
          out_d.sample_index     = idx_sum[DataWidth-1:0];
          out_d.last_sample      = last_q;
          state_d                = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      top_q       <= '0;
      cnt_q       <= '0;
      pos_q       <= '1;
      picks_q     <= '0;
      copy_q      <= 1'b0;
      final_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      top_q       <= top_d;
      cnt_q       <= cnt_d;
      pos_q       <= pos_d;
      picks_q     <= picks_d;
      copy_q      <= copy_d;
      final_q     <= final_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= last_d;
    frac_q <= frac_d;
    quot_q <= quot_d;
    prod_q <= prod_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The quotient only stays inside Q0.32 while fewer rows are left to skip than remain.
  `SRS_ASSERT_SAME(a_top_below_cnt, cnt_q != '0, top_q < cnt_q)
  // Whole-population mode never skips rows.
  `SRS_ASSERT_SAME(a_copy_no_skip, copy_q, top_q == '0)
  // A free output slot in the emit state always yields a result beat next cycle.
  `SRS_ASSERT_NEXT(a_emit_lands, (state_q == ST_EMIT) && (!out_valid_q || out_ready_i),
                   out_valid_o && (state_q == ST_IDLE))

endmodule

@@ hdl/srs_div.sv @@
// Restoring divider, one quotient bit per cycle; needs hi below the divisor.
module srs_div import srs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DataWidth-1:0]     rem_q, rem_d;
  logic [DataWidth-1:0]     lo_q, lo_d;
  logic [DataWidth-1:0]     dvs_q, dvs_d;
  logic [DivCountWidth-1:0] cnt_q, cnt_d;
  logic                     busy_q, busy_d;
  logic                     done_q, done_d;
  logic [DataWidth:0]       trial;
  logic [DataWidth:0]       diff;

  always_comb begin
    trial  = {rem_q, lo_q[DataWidth-1]};
    diff   = trial - {1'b0, dvs_q};
    rem_d  = rem_q;
    lo_d   = lo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = req_i.hi;
      lo_d   = req_i.lo;
      dvs_d  = req_i.divisor;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[DataWidth]) begin
        rem_d = diff[DataWidth-1:0];
        lo_d  = {lo_q[DataWidth-2:0], 1'b1};
      end else begin
        rem_d = trial[DataWidth-1:0];
        lo_d  = {lo_q[DataWidth-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCountWidth'(DataWidth - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lo_q  <= lo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = lo_q;
  assign rsp_o.remainder = rem_q;

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the sequential random sampler.
module tb_top;
  import srs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The watchdog fires when no beat moves on either channel for this long.
  // The slowest pick here skips at most a few dozen rows, each through one
  // multiply and one division, and the receiver holds off for one long stretch.
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned HoldCycles = 300;

  logic      clk_i;
  logic      rst_ni;
  logic      cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [DataWidth-1:0] cfg_data_i;
  logic      in_valid_i;
  logic      in_ready_o;
  in_beat_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_beat_t out_data_o;

  sequential_random_sampler i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Idle percentages of both sides, changed between phases.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  // Set by the stimulus to ask the receiver for one long hold-off.
  bit          hold_request;
  int unsigned hold_count;

  int unsigned mismatches;
  int unsigned beats_sent;
  int unsigned stall_cycles;

  // Shadow copy of the configuration registers.
  logic [31:0] cfg_population;
  logic [31:0] cfg_sample;
  logic [31:0] cfg_base;

  // Shadow copy of the sampler's working state.
  logic [31:0] rows_to_skip;
  logic [31:0] rows_left;
  logic [32:0] last_row;
  logic [31:0] picks_to_go;
  bit          whole_population;

  // Sample indices still owed by the block, oldest first.
  out_beat_t   expected_picks[$];

  // Works out what one accepted beat makes the sampler return, and queues it.
  task automatic sampler_predict(input in_beat_t beat);
    logic [63:0] frac;
    logic [63:0] quot;
    logic [32:0] jump;
    out_beat_t   pick;
    if (cmd_e'(beat.command) == CMD_RESTART) begin
      last_row = '1;
      if (cfg_sample == 0) begin
        whole_population = 1'b0;
        picks_to_go      = '0;
        rows_to_skip     = '0;
        rows_left        = '0;
      end else if (cfg_population <= cfg_sample) begin
        whole_population = 1'b1;
        picks_to_go      = cfg_population;
        rows_to_skip     = '0;
        rows_left        = cfg_population;
      end else begin
        whole_population = 1'b0;
        picks_to_go      = cfg_sample;
        rows_to_skip     = cfg_population - cfg_sample;
        rows_left        = cfg_population;
      end
      return;
    end
    if (picks_to_go == 0) return;
    if (whole_population) begin
      last_row    = last_row + 33'd1;
      picks_to_go = picks_to_go - 1;
      pick.last_sample = (picks_to_go == 0);
    end else if (picks_to_go > 1) begin
      // Skip rows while the running quotient stays above the random fraction.
      frac = {32'd0, beat.random_value, 1'b0};
      quot = '0;
      jump = '0;
      if (rows_left != 0) quot = {rows_to_skip, 32'd0} / {32'd0, rows_left};
      while (quot > frac && rows_to_skip != 0 && rows_left != 0) begin
        jump         = jump + 33'd1;
        rows_to_skip = rows_to_skip - 1;
        rows_left    = rows_left - 1;
        if (rows_left != 0) quot = (quot * {32'd0, rows_to_skip}) / {32'd0, rows_left};
        else quot = '0;
      end
      last_row = last_row + jump + 33'd1;
      if (rows_left != 0) rows_left = rows_left - 1;
      picks_to_go = picks_to_go - 1;
      pick.last_sample = 1'b0;
    end else begin
      // The final pick lands uniformly among the rows still left.
      jump = '0;
      if (rows_left != 0) jump = {2'd0, beat.random_value} % {1'b0, rows_left};
      last_row    = last_row + jump + 33'd1;
      picks_to_go = '0;
      pick.last_sample = 1'b1;
    end
    pick.sample_index = last_row[31:0] + cfg_base;
    expected_picks.push_back(pick);
  endtask

  // Offers one beat, possibly after a random gap, and waits until the block takes it.
  // Valid is lowered only at the start of a gap, so that two beats in a row
  // keep it high without a drop inside one time step.
  task automatic send_beat(input cmd_e cmd, input logic [RandWidth-1:0] rnd);
    in_beat_t beat;
    beat.command      = cmd;
    beat.random_value = rnd;
    if (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    sampler_predict(beat);
    beats_sent++;
  endtask

  function automatic logic [RandWidth-1:0] rand_word();
    return RandWidth'($urandom);
  endfunction

  // Stops offering beats and waits until every owed index has arrived, and then
  // lets a restart or an empty draw still in work finish.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_picks.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Writes all three registers; only called while the block is idle.
  task automatic configure(input logic [31:0] population, input logic [31:0] sample,
                           input logic [31:0] base);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_POPULATION;
    cfg_data_i <= population;
    @(posedge clk_i);
    cfg_idx_i  <= REG_SAMPLE;
    cfg_data_i <= sample;
    @(posedge clk_i);
    cfg_idx_i  <= REG_BASE;
    cfg_data_i <= base;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_population = population;
    cfg_sample     = sample;
    cfg_base       = base;
  endtask

  // Corner cases: never-loaded state, empty sample, whole population with
  // offset wrap, exhausted sample, extreme random words and huge sizes.
  task automatic test_directed();
    send_beat(CMD_DRAW, '1);
    drain();
    configure(32'd0, 32'd0, 32'd0);
    send_beat(CMD_RESTART, '0);
    send_beat(CMD_DRAW, '1);
    drain();
    configure(32'd5, 32'd5, 32'hFFFF_FFFE);
    send_beat(CMD_RESTART, '0);
    repeat (6) send_beat(CMD_DRAW, rand_word());
    drain();
    configure(32'd10, 32'd3, 32'd0);
    send_beat(CMD_RESTART, '1);
    send_beat(CMD_DRAW, '0);
    send_beat(CMD_DRAW, '1);
    send_beat(CMD_DRAW, '1);
    send_beat(CMD_DRAW, '0);
    drain();
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd7);
    send_beat(CMD_RESTART, '0);
    send_beat(CMD_DRAW, '0);
    send_beat(CMD_DRAW, '1);
    drain();
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(CMD_RESTART, '0);
    send_beat(CMD_DRAW, '0);
    send_beat(CMD_DRAW, '1);
    drain();
    configure(32'd1, 32'd1, 32'd0);
    send_beat(CMD_RESTART, '0);
    send_beat(CMD_DRAW, '0);
    drain();
  endtask

  // Random configurations, each followed mostly by a restart and a full run
  // of draws, with stray restarts and draws past the end mixed in.
  task automatic test_random(input int unsigned count);
    int unsigned target;
    logic [31:0] population;
    logic [31:0] sample;
    int unsigned draws;
    target = beats_sent + count;
    while (beats_sent < target) begin
      drain();
      case ($urandom_range(9, 0))
        0: begin
          population = $urandom;
          sample     = population - $urandom_range(3, 0);
        end
        1: begin
          population = $urandom_range(40, 0);
          sample     = $urandom_range(32'hFFFF_FFFF, population);
        end
        default: begin
          population = $urandom_range(40, 1);
          sample     = $urandom_range(population + 2, 0);
        end
      endcase
      configure(population, sample, $urandom);
      send_beat(CMD_RESTART, rand_word());
      draws = (sample > 40) ? $urandom_range(6, 1) : sample + $urandom_range(2, 0);
      repeat (draws) begin
        if ($urandom_range(19, 0) == 0) send_beat(cmd_e'($urandom_range(1, 0)), rand_word());
        else send_beat(CMD_DRAW, rand_word());
      end
    end
  endtask

  // The receiver holds off for a long stretch while draws keep coming, so the
  // block fills its output and stalls its input; then the sender waits for
  // every owed index before going on.
  task automatic test_backpressure();
    drain();
    configure(32'd30, 32'd12, 32'h8000_0000);
    send_beat(CMD_RESTART, '0);
    hold_request = 1'b1;
    repeat (12) send_beat(CMD_DRAW, rand_word());
    drain();
  endtask

  // Receiver: random ready, one long hold-off on request, and the check of
  // each beat against the oldest owed index.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_count  = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_picks.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("unexpected beat: index %h last %b", out_data_o.sample_index,
                     out_data_o.last_sample);
        end else if (out_data_o !== expected_picks[0]) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("wrong beat: expected index %h last %b, got index %h last %b",
                     expected_picks[0].sample_index, expected_picks[0].last_sample,
                     out_data_o.sample_index, out_data_o.last_sample);
          void'(expected_picks.pop_front());
        end else begin
          void'(expected_picks.pop_front());
        end
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_count   = HoldCycles;
      end
      if (hold_count != 0) begin
        hold_count--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !(recv_idle_pct != 0 && $urandom_range(99, 0) < recv_idle_pct);
      end
    end
  end

  // Watchdog on cycles with no beat moving on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= StallLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = REG_POPULATION;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    hold_request = 1'b0;
    mismatches   = 0;
    beats_sent   = 0;
    stall_cycles = 0;
    send_idle_pct = 23;
    recv_idle_pct = 62;
    // Shadow state starts where the block's reset leaves it.
    cfg_population = '0;
    cfg_sample     = '0;
    cfg_base       = '0;
    rows_to_skip   = '0;
    rows_left      = '0;
    last_row       = '1;
    picks_to_go    = '0;
    whole_population = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(380);
    send_idle_pct = 62;
    recv_idle_pct = 23;
    test_random(380);
    test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(380);
    drain();
    repeat (50) @(posedge clk_i);

    if (mismatches == 0 && expected_picks.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
